>>> sv/biq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad low-pass package
// Shared widths, register indexes, reset coefficients and control types.
// ----------------------------------------------------------------------------
package biq_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 28;
    localparam int STATE_BITS     = 40;
    localparam int COEF_BITS      = 32;
    localparam int DATA_BITS      = 32;
    localparam int ADDR_BITS      = 5;
    localparam int REG_IDX_BITS   = 3;
    localparam int TDATA_BITS     = ((SAMPLE_BITS + 7) / 8) * 8;

    localparam int SPLIT_BITS     = 32;
    localparam int HI_BITS        = STATE_BITS - SPLIT_BITS;
    localparam int PROD_BITS      = STATE_BITS + COEF_BITS;
    localparam int LO_PROD_BITS   = SPLIT_BITS + COEF_BITS;
    localparam int HI_PROD_BITS   = HI_BITS + COEF_BITS;
    localparam int QUO_BITS       = PROD_BITS - COEF_FRAC_BITS;
    localparam int ACC_BITS       = STATE_BITS + 3;

    localparam logic [REG_IDX_BITS-1:0] REG_BYPASS = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_B0     = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_B1     = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_B2     = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_A1     = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_A2     = 3'd5;

    localparam logic signed [COEF_BITS-1:0] RST_B0 = 32'sd881561;
    localparam logic signed [COEF_BITS-1:0] RST_B1 = -32'sd1567664;
    localparam logic signed [COEF_BITS-1:0] RST_B2 = 32'sd881561;
    localparam logic signed [COEF_BITS-1:0] RST_A1 = -32'sd526545741;
    localparam logic signed [COEF_BITS-1:0] RST_A2 = 32'sd258305745;

    typedef struct packed {
        logic                        bypass;
        logic signed [COEF_BITS-1:0] b0;
        logic signed [COEF_BITS-1:0] b1;
        logic signed [COEF_BITS-1:0] b2;
        logic signed [COEF_BITS-1:0] a1;
        logic signed [COEF_BITS-1:0] a2;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ROUND,
        ST_ACCUM,
        ST_NODE,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        PR_A1D1,
        PR_A2D2,
        PR_B0W,
        PR_B1D1,
        PR_B2D2
    } prod_t;

    typedef struct packed {
        logic  load;
        logic  mul_lo;
        logic  mul_hi;
        logic  round;
        logic  accum;
        logic  node;
        logic  finish;
        prod_t prod;
    } cmd_t;

endpackage

>>> sv/biquad_lowpass_df2_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad low-pass filter, direct form II
// Top level: APB configuration, sequencing controller and shared datapath.
// ----------------------------------------------------------------------------
// Each 24-bit sample beat is filtered as w = x - a1*d1 - a2*d2 and
// y = b0*w + b1*d1 + b2*d2 with Q3.28 coefficients, rounded products and
// saturated 40-bit state and 24-bit output. A split multiplier forms each of
// the five products as a 32x32 low half followed by an 8x32 high half, then
// rounds it and accumulates it. A new sample is accepted only after the last
// one has finished, and finishing waits while the output is stalled. With
// bypass set, a sample is returned unchanged. The output register holds a
// finished result while the next sample is being accepted.
module biquad_lowpass_df2_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [biq_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [biq_pkg::DATA_BITS-1:0]     pwdata,
    output logic [biq_pkg::DATA_BITS-1:0]     prdata,
    output logic                              pready,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [biq_pkg::TDATA_BITS-1:0]    s_tdata,  // [23:0] sample_in
    input  logic                              s_tuser,  // [0] restart
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [biq_pkg::TDATA_BITS-1:0]    m_tdata   // [23:0] sample_out
);

    biq_pkg::cfg_t                           cfg;
    biq_pkg::cmd_t                           cmd;
    logic signed [biq_pkg::SAMPLE_BITS-1:0]  sample_out;

    biq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    biq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .bypass   (cfg.bypass),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    biq_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg        (cfg),
        .sample_in  (s_tdata[biq_pkg::SAMPLE_BITS-1:0]),
        .restart    (s_tuser),
        .sample_out (sample_out)
    );

    assign m_tdata = biq_pkg::TDATA_BITS'($unsigned(sample_out));

endmodule

>>> sv/biq_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad configuration registers
// APB register file holding the bypass flag and the five coefficients.
// ----------------------------------------------------------------------------
module biq_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [biq_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [biq_pkg::DATA_BITS-1:0]   pwdata,
    output logic [biq_pkg::DATA_BITS-1:0]   prdata,
    output logic                            pready,
    output biq_pkg::cfg_t                   cfg
);

    biq_pkg::cfg_t                        cfg_reg;
    biq_pkg::cfg_t                        cfg_next;
    logic [biq_pkg::REG_IDX_BITS-1:0]     reg_idx;
    logic                                 wr_en;

    assign reg_idx = paddr[biq_pkg::ADDR_BITS-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                biq_pkg::REG_BYPASS: cfg_next.bypass = pwdata[0];
                biq_pkg::REG_B0:     cfg_next.b0     = pwdata;
                biq_pkg::REG_B1:     cfg_next.b1     = pwdata;
                biq_pkg::REG_B2:     cfg_next.b2     = pwdata;
                biq_pkg::REG_A1:     cfg_next.a1     = pwdata;
                biq_pkg::REG_A2:     cfg_next.a2     = pwdata;
                default:             cfg_next        = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            biq_pkg::REG_BYPASS: prdata = biq_pkg::DATA_BITS'(cfg_reg.bypass);
            biq_pkg::REG_B0:     prdata = cfg_reg.b0;
            biq_pkg::REG_B1:     prdata = cfg_reg.b1;
            biq_pkg::REG_B2:     prdata = cfg_reg.b2;
            biq_pkg::REG_A1:     prdata = cfg_reg.a1;
            biq_pkg::REG_A2:     prdata = cfg_reg.a2;
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bypass <= 1'b0;
            cfg_reg.b0     <= biq_pkg::RST_B0;
            cfg_reg.b1     <= biq_pkg::RST_B1;
            cfg_reg.b2     <= biq_pkg::RST_B2;
            cfg_reg.a1     <= biq_pkg::RST_A1;
            cfg_reg.a2     <= biq_pkg::RST_A2;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> sv/biq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad controller
// Sequences the five products of one sample and owns both stream handshakes.
// ----------------------------------------------------------------------------
module biq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           bypass,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output biq_pkg::cmd_t  cmd
);

    biq_pkg::state_t state_reg;
    biq_pkg::state_t state_next;
    biq_pkg::prod_t  prod_reg;
    biq_pkg::prod_t  prod_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        prod_next  = prod_reg;
        unique case (state_reg)
            biq_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    prod_next  = biq_pkg::PR_A1D1;
                    state_next = bypass ? biq_pkg::ST_FINISH : biq_pkg::ST_MUL_LO;
                end
            end
            biq_pkg::ST_MUL_LO: state_next = biq_pkg::ST_MUL_HI;
            biq_pkg::ST_MUL_HI: state_next = biq_pkg::ST_ROUND;
            biq_pkg::ST_ROUND:  state_next = biq_pkg::ST_ACCUM;
            biq_pkg::ST_ACCUM:
            begin
                unique case (prod_reg)
                    biq_pkg::PR_A1D1:
                    begin
                        prod_next  = biq_pkg::PR_A2D2;
                        state_next = biq_pkg::ST_MUL_LO;
                    end
                    biq_pkg::PR_A2D2:
                    begin
                        prod_next  = biq_pkg::PR_B0W;
                        state_next = biq_pkg::ST_NODE;
                    end
                    biq_pkg::PR_B0W:
                    begin
                        prod_next  = biq_pkg::PR_B1D1;
                        state_next = biq_pkg::ST_MUL_LO;
                    end
                    biq_pkg::PR_B1D1:
                    begin
                        prod_next  = biq_pkg::PR_B2D2;
                        state_next = biq_pkg::ST_MUL_LO;
                    end
                    default:
                    begin
                        state_next = biq_pkg::ST_FINISH;
                    end
                endcase
            end
            biq_pkg::ST_NODE:   state_next = biq_pkg::ST_MUL_LO;
            biq_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = biq_pkg::ST_IDLE;
                end
            end
            default:            state_next = biq_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.prod   = prod_reg;
        unique case (state_reg)
            biq_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            biq_pkg::ST_MUL_LO: cmd.mul_lo = 1'b1;
            biq_pkg::ST_MUL_HI: cmd.mul_hi = 1'b1;
            biq_pkg::ST_ROUND:  cmd.round  = 1'b1;
            biq_pkg::ST_ACCUM:  cmd.accum  = 1'b1;
            biq_pkg::ST_NODE:   cmd.node   = 1'b1;
            biq_pkg::ST_FINISH: cmd.finish = out_free;
            default:            cmd        = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= biq_pkg::ST_IDLE;
            prod_reg      <= biq_pkg::PR_A1D1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prod_reg      <= prod_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> sv/biq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad datapath
// Shared split multiplier with rounding, accumulator, delay line and output.
// ----------------------------------------------------------------------------
module biq_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  biq_pkg::cmd_t                          cmd,
    input  biq_pkg::cfg_t                          cfg,
    input  logic signed [biq_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic                                   restart,
    output logic signed [biq_pkg::SAMPLE_BITS-1:0] sample_out
);

    localparam int SB = biq_pkg::SAMPLE_BITS;
    localparam int WB = biq_pkg::STATE_BITS;
    localparam int CB = biq_pkg::COEF_BITS;
    localparam int AB = biq_pkg::ACC_BITS;
    localparam int PB = biq_pkg::PROD_BITS;
    localparam int QB = biq_pkg::QUO_BITS;
    localparam int FB = biq_pkg::COEF_FRAC_BITS;

    localparam logic [PB-1:0] ROUND_ONE = PB'(1) << (FB - 1);
    localparam logic [QB-1:0] LIM_NEG   = QB'(1) << (WB - 1);
    localparam logic [QB-1:0] LIM_POS   = LIM_NEG - QB'(1);

    function automatic logic signed [WB-1:0] sat_state(input logic signed [AB-1:0] v);
        logic [AB-WB:0] top;
        top = v[AB-1:WB-1];
        if (!v[AB-1] && (|top))
        begin
            sat_state = {1'b0, {(WB-1){1'b1}}};
        end
        else if (v[AB-1] && !(&top))
        begin
            sat_state = {1'b1, {(WB-1){1'b0}}};
        end
        else
        begin
            sat_state = v[WB-1:0];
        end
    endfunction

    function automatic logic signed [SB-1:0] sat_sample(input logic signed [AB-1:0] v);
        logic [AB-SB:0] top;
        top = v[AB-1:SB-1];
        if (!v[AB-1] && (|top))
        begin
            sat_sample = {1'b0, {(SB-1){1'b1}}};
        end
        else if (v[AB-1] && !(&top))
        begin
            sat_sample = {1'b1, {(SB-1){1'b0}}};
        end
        else
        begin
            sat_sample = v[SB-1:0];
        end
    endfunction

    logic signed [WB-1:0]                    d1_reg, d1_next;
    logic signed [WB-1:0]                    d2_reg, d2_next;
    logic signed [WB-1:0]                    w_reg, w_next;
    logic signed [AB-1:0]                    acc_reg, acc_next;
    logic signed [SB-1:0]                    x_reg, x_next;
    logic signed [SB-1:0]                    out_reg, out_next;
    logic [biq_pkg::HI_BITS-1:0]             hi_mag_reg, hi_mag_next;
    logic [CB-1:0]                           coef_mag_reg, coef_mag_next;
    logic                                    neg_reg, neg_next;
    logic                                    sub_reg, sub_next;
    logic [biq_pkg::LO_PROD_BITS-1:0]        prod_lo_reg, prod_lo_next;
    logic [biq_pkg::HI_PROD_BITS-1:0]        prod_hi_reg, prod_hi_next;
    logic signed [WB-1:0]                    term_reg, term_next;

    logic signed [WB-1:0]                    op_val;
    logic signed [CB-1:0]                    op_coef;
    logic                                    op_sub;
    logic [WB-1:0]                           val_mag;
    logic [CB-1:0]                           coef_mag;
    logic [PB-1:0]                           rnd_sum;
    logic [QB-1:0]                           quo;
    logic [QB-1:0]                           neg_quo;

    always_comb
    begin
        unique case (cmd.prod)
            biq_pkg::PR_A1D1:
            begin
                op_val  = d1_reg;
                op_coef = cfg.a1;
                op_sub  = 1'b1;
            end
            biq_pkg::PR_A2D2:
            begin
                op_val  = d2_reg;
                op_coef = cfg.a2;
                op_sub  = 1'b1;
            end
            biq_pkg::PR_B0W:
            begin
                op_val  = w_reg;
                op_coef = cfg.b0;
                op_sub  = 1'b0;
            end
            biq_pkg::PR_B1D1:
            begin
                op_val  = d1_reg;
                op_coef = cfg.b1;
                op_sub  = 1'b0;
            end
            biq_pkg::PR_B2D2:
            begin
                op_val  = d2_reg;
                op_coef = cfg.b2;
                op_sub  = 1'b0;
            end
            default:
            begin
                op_val  = '0;
                op_coef = '0;
                op_sub  = 1'b0;
            end
        endcase
    end

    assign val_mag  = op_val[WB-1] ? WB'(-op_val) : WB'(op_val);
    assign coef_mag = op_coef[CB-1] ? CB'(-op_coef) : CB'(op_coef);

    assign rnd_sum = (PB'(prod_hi_reg) << biq_pkg::SPLIT_BITS) + PB'(prod_lo_reg) + ROUND_ONE;
    assign quo     = rnd_sum[PB-1:FB];
    assign neg_quo = QB'(0) - ((quo > LIM_NEG) ? LIM_NEG : quo);

    always_comb
    begin
        d1_next       = d1_reg;
        d2_next       = d2_reg;
        w_next        = w_reg;
        acc_next      = acc_reg;
        x_next        = x_reg;
        out_next      = out_reg;
        hi_mag_next   = hi_mag_reg;
        coef_mag_next = coef_mag_reg;
        neg_next      = neg_reg;
        sub_next      = sub_reg;
        prod_lo_next  = prod_lo_reg;
        prod_hi_next  = prod_hi_reg;
        term_next     = term_reg;

        if (cmd.load)
        begin
            x_next   = sample_in;
            acc_next = AB'(sample_in);
            if (restart)
            begin
                d1_next = '0;
                d2_next = '0;
            end
        end

        if (cmd.mul_lo)
        begin
            prod_lo_next  = biq_pkg::LO_PROD_BITS'(val_mag[biq_pkg::SPLIT_BITS-1:0])
                          * biq_pkg::LO_PROD_BITS'(coef_mag);
            hi_mag_next   = val_mag[WB-1:biq_pkg::SPLIT_BITS];
            coef_mag_next = coef_mag;
            neg_next      = op_val[WB-1] ^ op_coef[CB-1];
            sub_next      = op_sub;
        end

        if (cmd.mul_hi)
        begin
            prod_hi_next = biq_pkg::HI_PROD_BITS'(hi_mag_reg)
                         * biq_pkg::HI_PROD_BITS'(coef_mag_reg);
        end

        if (cmd.round)
        begin
            if (neg_reg)
            begin
                term_next = neg_quo[WB-1:0];
            end
            else
            begin
                term_next = (quo > LIM_POS) ? LIM_POS[WB-1:0] : quo[WB-1:0];
            end
        end

        if (cmd.accum)
        begin
            if (sub_reg)
            begin
                acc_next = acc_reg - AB'(term_reg);
            end
            else
            begin
                acc_next = acc_reg + AB'(term_reg);
            end
        end

        if (cmd.node)
        begin
            w_next   = sat_state(acc_reg);
            acc_next = '0;
        end

        if (cmd.finish)
        begin
            if (cfg.bypass)
            begin
                out_next = x_reg;
            end
            else
            begin
                out_next = sat_sample(acc_reg);
                d2_next  = d1_reg;
                d1_next  = w_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_reg <= '0;
            d2_reg <= '0;
        end
        else
        begin
            d1_reg <= d1_next;
            d2_reg <= d2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg        <= w_next;
        acc_reg      <= acc_next;
        x_reg        <= x_next;
        out_reg      <= out_next;
        hi_mag_reg   <= hi_mag_next;
        coef_mag_reg <= coef_mag_next;
        neg_reg      <= neg_next;
        sub_reg      <= sub_next;
        prod_lo_reg  <= prod_lo_next;
        prod_hi_reg  <= prod_hi_next;
        term_reg     <= term_next;
    end

    assign sample_out = out_reg;

endmodule

>>> sv/biq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad port checker
// Port-level assertions on the stream and register interfaces.
// ----------------------------------------------------------------------------
module biq_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [biq_pkg::ADDR_BITS-1:0]     paddr,
    input logic [biq_pkg::DATA_BITS-1:0]     pwdata,
    input logic [biq_pkg::DATA_BITS-1:0]     prdata,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [biq_pkg::TDATA_BITS-1:0]    m_tdata
);

    // A beat taken on the input side keeps the filter busy for the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while the filter was still busy");

    // A new result only appears at the end of a sample, while input is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a sample in progress");

    // A stalled output beat holds its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled output beat changed or dropped");

    // A b0 coefficient written is read back on the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr[biq_pkg::ADDR_BITS-1:2] == biq_pkg::REG_B0)
        |=> (!(psel && !pwrite && paddr[biq_pkg::ADDR_BITS-1:2] == biq_pkg::REG_B0)
             || prdata == $past(pwdata)))
        else $error("coefficient read back does not match the value written");

endmodule

bind biquad_lowpass_df2_top biq_checker u_biq_checker (.*);
